// File: src/crc16fr_pkg.sv
// shared types, constants and crc function of the framed command receiver
package crc16fr_pkg;

  // frame layout: start, sequence and length bytes ahead of the payload
  localparam int HDR_LEN = 3;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // request queue between front and back
  localparam int QUEUE_AW = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // channel widths
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_EOW     = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_STATUS  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_IDLE   = 3'd0,
    STAT_LOCKED = 3'd1,
    STAT_READY  = 3'd2,
    STAT_BUSY   = 3'd3,
    STAT_ERROR  = 3'd4
  } status_t;

  // one classified request as it travels through the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       host_busy;
    logic       response_pending;
    logic       unlocked;
  } q_item_t;

  // crc-16/ccitt over one byte, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/crc16fr_front.sv
// front end: takes requests, classifies them and queues them for the back end
module crc16fr_front import crc16fr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output q_item_t              q_item
);

  q_item_t              q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;
  logic                 push, pop;
  q_item_t              item_in;
  cmd_t                 cmd_in;

  // classify the incoming request; only data bytes keep their byte
  always_comb begin
    cmd_in = cmd_t'(in_tuser);
    item_in.cmd = cmd_in;
    item_in.data = (cmd_in == CMD_DATA) ? in_tdata[7:0] : 8'h00;
    item_in.host_busy = in_tdata[8];
    item_in.response_pending = in_tdata[9];
    item_in.unlocked = in_tdata[10];
  end

  // queue handshake
  assign in_tready = (cnt_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign push = in_tvalid && in_tready;
  assign pop = q_valid && q_ready;
  assign q_item = q_mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: src/crc16fr_back.sv
// back end: frame assembly, crc check, payload store and result output
module crc16fr_back import crc16fr_pkg::*; #(
  parameter int PAYLOAD_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            start_of_command,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  q_item_t               q_item,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int CHECKED_LEN = HDR_LEN + PAYLOAD_LEN;
  localparam int FRAME_LEN = CHECKED_LEN + 2;
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam int AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_SEQ = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_LEN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_LEN);
  localparam logic [CNT_W-1:0] CNT_CHECKED = CNT_W'(CHECKED_LEN);
  localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_LEN);
  localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_LEN - 1);
  localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_LEN);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CONS = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        hdr_start_r, hdr_start_nxt;
  logic [7:0]        hdr_seq_r, hdr_seq_nxt;
  logic [7:0]        hdr_len_r, hdr_len_nxt;
  logic [15:0]       recv_check_r, recv_check_nxt;
  logic              frame_done_r, frame_done_nxt;
  logic              error_seen_r, error_seen_nxt;
  logic [7:0]        latched_seq_r, latched_seq_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;

  // payload store and its registered read port
  logic [7:0]        store_mem [PAYLOAD_LEN];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r;
  logic [2:0]        out_status_r;
  logic [7:0]        out_payload_r;
  logic [7:0]        out_seq_r;
  logic              out_last_r;
  logic              load_out;
  logic              load_kind;
  status_t           load_status;
  logic [7:0]        load_payload;
  logic              load_last;

  logic              out_free;
  logic              frame_good;
  status_t           status_now;
  logic [CNT_W-1:0]  pos;

  assign out_free = !out_valid_r || out_tready;
  assign pos = byte_count_r;
  assign frame_good = (byte_count_r == CNT_FRAME) && (hdr_start_r == start_of_command) &&
                      (hdr_len_r == LEN_BYTE) && (crc_r == recv_check_r);

  // status priority: error, busy, ready, locked, idle
  always_comb begin
    if (error_seen_r) begin
      status_now = STAT_ERROR;
    end else if (frame_done_r || q_item.host_busy) begin
      status_now = STAT_BUSY;
    end else if (q_item.response_pending) begin
      status_now = STAT_READY;
    end else if (!q_item.unlocked) begin
      status_now = STAT_LOCKED;
    end else begin
      status_now = STAT_IDLE;
    end
  end

  // request execution
  always_comb begin
    state_nxt = state_r;
    byte_count_nxt = byte_count_r;
    crc_nxt = crc_r;
    hdr_start_nxt = hdr_start_r;
    hdr_seq_nxt = hdr_seq_r;
    hdr_len_nxt = hdr_len_r;
    recv_check_nxt = recv_check_r;
    frame_done_nxt = frame_done_r;
    error_seen_nxt = error_seen_r;
    latched_seq_nxt = latched_seq_r;
    idx_nxt = idx_r;
    q_ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = AW'(pos - CNT_HDR);
    rd_en = 1'b0;
    rd_addr = idx_r;
    load_out = 1'b0;
    load_kind = 1'b0;
    load_status = STAT_IDLE;
    load_payload = 8'h00;
    load_last = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.cmd)
            CMD_DATA: begin
              q_ready = 1'b1;
              if (!frame_done_r && (pos < CNT_FRAME)) begin
                if (pos < CNT_CHECKED) begin
                  crc_nxt = crc16_byte(crc_r, q_item.data);
                end
                if (pos == '0) begin
                  hdr_start_nxt = q_item.data;
                end else if (pos == CNT_SEQ) begin
                  hdr_seq_nxt = q_item.data;
                end else if (pos == CNT_LEN) begin
                  hdr_len_nxt = q_item.data;
                end else if (pos < CNT_CHECKED) begin
                  mem_we = 1'b1;
                end else if (pos == CNT_CHECKED) begin
                  recv_check_nxt = {q_item.data, recv_check_r[7:0]};
                end else begin
                  recv_check_nxt = {recv_check_r[15:8], q_item.data};
                end
                byte_count_nxt = pos + 1'b1;
              end
            end
            CMD_EOW: begin
              q_ready = 1'b1;
              if (!frame_done_r) begin
                if (frame_good) begin
                  latched_seq_nxt = hdr_seq_r;
                  frame_done_nxt = 1'b1;
                  error_seen_nxt = 1'b0;
                end else begin
                  error_seen_nxt = 1'b1;
                end
                byte_count_nxt = '0;
                crc_nxt = CRC_INIT;
              end
            end
            CMD_CONSUME: begin
              q_ready = 1'b1;
              if (frame_done_r) begin
                rd_en = 1'b1;
                rd_addr = '0;
                idx_nxt = '0;
                frame_done_nxt = 1'b0;
                state_nxt = S_CONS;
              end
            end
            CMD_STATUS: begin
              if (out_free) begin
                q_ready = 1'b1;
                load_out = 1'b1;
                load_status = status_now;
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end
      S_CONS: begin
        // stream the store, one byte per free output slot
        if (out_free) begin
          load_out = 1'b1;
          load_kind = 1'b1;
          load_payload = rd_data_r;
          load_last = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      byte_count_r <= '0;
      crc_r <= CRC_INIT;
      hdr_start_r <= '0;
      hdr_seq_r <= '0;
      hdr_len_r <= '0;
      recv_check_r <= '0;
      frame_done_r <= 1'b0;
      error_seen_r <= 1'b0;
      latched_seq_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      byte_count_r <= byte_count_nxt;
      crc_r <= crc_nxt;
      hdr_start_r <= hdr_start_nxt;
      hdr_seq_r <= hdr_seq_nxt;
      hdr_len_r <= hdr_len_nxt;
      recv_check_r <= recv_check_nxt;
      frame_done_r <= frame_done_nxt;
      error_seen_r <= error_seen_nxt;
      latched_seq_r <= latched_seq_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind_r <= load_kind;
      out_status_r <= load_status;
      out_payload_r <= load_payload;
      out_seq_r <= latched_seq_r;
      out_last_r <= load_last;
    end
  end

  // payload store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= q_item.data;
    end
  end

  // payload store read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_kind_r;
  assign out_tlast = out_last_r;
  assign out_tdata = {5'b00000, out_seq_r, out_payload_r, out_status_r};

endmodule

// File: src/crc16_framed_command_receiver_core.sv
// top level of the crc-16 framed command receiver
//
//  channel  direction  signals                        contents
//  in_      slave      tvalid tready tdata tuser      one request: byte, end, consume, status
//  out_     master     tvalid tready tdata tuser tlast status or payload byte result
//  cfg_     write      wr_en wr_data                  expected start byte
//
// a request is queued when accepted; the back end executes one request per cycle
// while not streaming (a status query waits for a free output slot); a consume
// streams PAYLOAD_LEN bytes, one per cycle with the output free, after the first store read
// reset clears the queue, byte count, crc, flags and output valid; the payload
// store is not cleared
// out_tready low holds the output register; the next status query or payload byte
// waits behind it, requests after it wait in the four-entry queue and in_tready
// drops once that queue is full
module crc16_framed_command_receiver_core import crc16fr_pkg::*; #(
  parameter int PAYLOAD_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // data_byte [7:0], host_busy [8], response_pending [9], unlocked [10]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command [1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status_code [2:0], payload_byte [10:3], sequence_res [18:11]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind [0]
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);

  logic [7:0] start_of_command_r;
  logic       q_valid;
  logic       q_ready;
  q_item_t    q_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_of_command_r <= '0;
    end else if (cfg_wr_en) begin
      start_of_command_r <= cfg_wr_data;
    end
  end

  crc16fr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  crc16fr_back #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .start_of_command (start_of_command_r),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast)
  );

endmodule

// File: src/crc16fr_checker.sv
// port-level checks of the framed command receiver and their binding
module crc16fr_checker import crc16fr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its content
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a status result is a single-item run with a defined code
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata[2:0] != 3'd5) &&
    (out_tdata[2:0] != 3'd6) && (out_tdata[2:0] != 3'd7))
    else $error("bad status result");

  // a payload byte carries no status code
  a_payload_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] == 3'd0)
    else $error("payload result with status code");

endmodule

bind crc16_framed_command_receiver_core crc16fr_checker u_checker (.*);

// File: dv/crc16_framed_command_receiver_core_test.sv
// self-checking testbench of the crc-16 framed command receiver core
`timescale 1ns / 100ps

module crc16_framed_command_receiver_core_test;
  import crc16fr_pkg::*;

  localparam int PAYLOAD_LEN = 64;
  localparam int CHECKED_BYTES = HDR_LEN + PAYLOAD_LEN;
  localparam int FRAME_BYTES = CHECKED_BYTES + 2;
  localparam logic [15:0] CCITT_SEED = 16'hFFFF;
  localparam logic [15:0] CCITT_POLY = 16'h1021;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE = 1'b1;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_CMDS = 8;

  // ways a generated frame can be spoiled
  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_LENGTH,
    FLAW_CHECK,
    FLAW_SHORT,
    FLAW_EXCESS
  } flaw_t;

  // one reply as the output channel carries it
  typedef struct packed {
    logic       kind;
    status_t    code;
    logic [7:0] pbyte;
    logic [7:0] seq;
    logic       tail;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [7:0]            cfg_wr_data = '0;

  crc16_framed_command_receiver_core #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // shadow state of the receiver
  logic [7:0]  start_byte = 8'h00;
  logic [7:0]  stored_payload [PAYLOAD_LEN];
  int          byte_pos = 0;
  logic [15:0] running_crc = CCITT_SEED;
  logic [7:0]  hdr_start = 8'h00;
  logic [7:0]  hdr_seq = 8'h00;
  logic [7:0]  hdr_len = 8'h00;
  logic [15:0] rx_check = 16'h0000;
  logic        frame_held = 1'b0;
  logic        error_flag = 1'b0;
  logic [7:0]  held_seq = 8'h00;

  reply_t awaited_replies [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int replies_checked = 0;
  int good_frames = 0;
  int rejected_frames = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // crc-16/ccitt, one message bit at a time from the msb
  function automatic logic [15:0] ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  // advance the shadow state by one request and queue the replies it causes
  task automatic track_request(input cmd_t cmd, input logic [7:0] d, input logic hb,
                               input logic rp, input logic un);
    reply_t r;
    r = '0;
    r.seq = held_seq;
    case (cmd)
      CMD_DATA: begin
        if (!frame_held && byte_pos < FRAME_BYTES) begin
          if (byte_pos < CHECKED_BYTES) running_crc = ccitt_step(running_crc, d);
          if (byte_pos == 0) hdr_start = d;
          else if (byte_pos == 1) hdr_seq = d;
          else if (byte_pos == 2) hdr_len = d;
          else if (byte_pos < CHECKED_BYTES) stored_payload[byte_pos - HDR_LEN] = d;
          else if (byte_pos == CHECKED_BYTES) rx_check[15:8] = d;
          else rx_check[7:0] = d;
          byte_pos++;
        end
      end
      CMD_EOW: begin
        if (!frame_held) begin
          if (byte_pos == FRAME_BYTES && hdr_start == start_byte &&
              hdr_len == 8'(PAYLOAD_LEN) && running_crc == rx_check) begin
            held_seq = hdr_seq;
            frame_held = 1'b1;
            error_flag = 1'b0;
            good_frames++;
          end else begin
            error_flag = 1'b1;
            rejected_frames++;
          end
          byte_pos = 0;
          running_crc = CCITT_SEED;
        end
      end
      CMD_CONSUME: begin
        if (frame_held) begin
          r.kind = KIND_BYTE;
          r.code = STAT_IDLE;
          for (int i = 0; i < PAYLOAD_LEN; i++) begin
            r.pbyte = stored_payload[i];
            r.tail = (i == PAYLOAD_LEN - 1);
            awaited_replies.push_back(r);
          end
          frame_held = 1'b0;
        end
      end
      default: begin
        r.kind = KIND_STATUS;
        r.tail = 1'b1;
        if (error_flag) r.code = STAT_ERROR;
        else if (frame_held || hb) r.code = STAT_BUSY;
        else if (rp) r.code = STAT_READY;
        else if (!un) r.code = STAT_LOCKED;
        else r.code = STAT_IDLE;
        awaited_replies.push_back(r);
      end
    endcase
  endtask

  // offer one request and hold it until accepted; tvalid stays high afterwards
  task automatic send_req(input cmd_t cmd, input logic [7:0] d, input logic hb,
                          input logic rp, input logic un);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {5'b00000, un, rp, hb, d};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    track_request(cmd, d, hb, rp, un);
  endtask

  // request with don't-care flags
  task automatic send_plain(input cmd_t cmd, input logic [7:0] d);
    send_req(cmd, d, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // build a frame, spoil it as asked, send its bytes and close the write
  task automatic send_frame(input logic [7:0] sob, input logic [7:0] seq, input flaw_t flaw,
                            input bit alt_fill);
    logic [7:0]  bytes_q [$];
    logic [15:0] crc;
    int          keep;
    bytes_q = {};
    bytes_q.push_back(flaw == FLAW_START ? sob ^ 8'($urandom_range(1, 255)) : sob);
    bytes_q.push_back(seq);
    bytes_q.push_back(flaw == FLAW_LENGTH ? 8'(PAYLOAD_LEN) ^ 8'($urandom_range(1, 255))
                                          : 8'(PAYLOAD_LEN));
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (alt_fill) bytes_q.push_back(i[0] ? 8'hFF : 8'h00);
      else bytes_q.push_back(8'($urandom));
    end
    crc = CCITT_SEED;
    foreach (bytes_q[i]) crc = ccitt_step(crc, bytes_q[i]);
    if (flaw == FLAW_CHECK) crc = crc ^ 16'($urandom_range(1, 65535));
    bytes_q.push_back(crc[15:8]);
    bytes_q.push_back(crc[7:0]);
    if (flaw == FLAW_SHORT) begin
      keep = $urandom_range(FRAME_BYTES - 1);
      while (bytes_q.size() > keep) void'(bytes_q.pop_back());
    end
    if (flaw == FLAW_EXCESS) begin
      repeat ($urandom_range(1, 6)) bytes_q.push_back(8'($urandom));
    end
    foreach (bytes_q[i]) send_plain(CMD_DATA, bytes_q[i]);
    send_plain(CMD_EOW, 8'($urandom));
  endtask

  // stop offering, let every reply drain and the request queue empty out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the expected start byte while the block is idle
  task automatic write_start_byte(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    start_byte = v;
  endtask

  // each status priority, a consume with nothing stored, an empty write
  task automatic test_status_priorities();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
    send_req(CMD_STATUS, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b1, 1'b0);
    send_req(CMD_STATUS, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_plain(CMD_CONSUME, 8'h00);
    send_plain(CMD_EOW, 8'hFF);
    send_req(CMD_STATUS, 8'h00, 1'b1, 1'b1, 1'b0);
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  // good frame with trailing bytes under the reset start byte, held while more bytes arrive
  task automatic test_good_frame();
    send_frame(start_byte, 8'hFF, FLAW_EXCESS, 1'b1);
    send_plain(CMD_DATA, 8'h00);
    send_plain(CMD_DATA, 8'hFF);
    send_plain(CMD_EOW, 8'h00);
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  // held frame drained under a long output hold-off while requests keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_left = LONG_HOLD;
    send_plain(CMD_CONSUME, 8'($urandom));
    repeat (8) send_plain(CMD_STATUS, 8'($urandom));
    send_plain(CMD_CONSUME, 8'($urandom));
  endtask

  // short and empty writes under a new start byte raise the error flag
  task automatic test_frame_errors();
    write_start_byte(8'hA5);
    send_frame(start_byte, 8'h11, FLAW_SHORT, 1'b0);
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
    send_plain(CMD_EOW, 8'h00);
    send_req(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  // one mostly well-formed frame with random content, then random commands and noise
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [7:0] sob, input int count);
    int    pick;
    flaw_t flaw;
    write_start_byte(sob);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    flaw = ($urandom_range(99) < 65) ? FLAW_NONE
                                     : flaw_t'($urandom_range(FLAW_START, FLAW_EXCESS));
    send_frame(start_byte, 8'($urandom), flaw, 1'b0);
    send_plain(CMD_CONSUME, 8'($urandom));
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_plain(CMD_CONSUME, 8'($urandom));
      end else if (pick < 60) begin
        send_plain(CMD_STATUS, 8'($urandom));
      end else if (pick < 80) begin
        send_plain(CMD_EOW, 8'($urandom));
      end else begin
        send_plain(CMD_DATA, 8'($urandom));
      end
    end
  endtask

  // output side: compare each accepted reply, then choose the next ready
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.code = status_t'(out_tdata[2:0]);
      got.pbyte = out_tdata[10:3];
      got.seq = out_tdata[18:11];
      got.tail = out_tlast;
      replies_checked++;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reply: kind %0d code %0d byte %h seq %h last %0d",
                   got.kind, got.code, got.pbyte, got.seq, got.tail);
      end else begin
        want = awaited_replies.pop_front();
        if (got.kind !== want.kind || got.code !== want.code || got.pbyte !== want.pbyte ||
            got.seq !== want.seq || got.tail !== want.tail) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("reply %0d expected: kind %0d code %0d byte %h seq %h last %0d",
                     replies_checked, want.kind, want.code, want.pbyte, want.seq, want.tail);
            $display("reply %0d actual:   kind %0d code %0d byte %h seq %h last %0d",
                     replies_checked, got.kind, got.code, got.pbyte, got.seq, got.tail);
          end
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles with no accepted request or reply
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no traffic for %0d cycles, %0d replies outstanding",
                 quiet_cycles, awaited_replies.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_status_priorities();
    test_good_frame();
    test_backpressure();
    test_frame_errors();
    test_random_traffic(49, 0, 8'hFF, RANDOM_CMDS);
    test_random_traffic(0, 49, 8'($urandom), RANDOM_CMDS);
    test_random_traffic(14, 14, 8'($urandom), RANDOM_CMDS);
    wait_idle();
    $display("run: %0d requests, %0d replies checked, %0d good and %0d rejected frames",
             requests_sent, replies_checked, good_frames, rejected_frames);
    $display("covered start byte 0x00, 0xA5, 0xFF and random, idle/stall mixes, long hold-off");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching replies", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
